@@ src/utsg_pkg.sv @@
// ----------------------------------------------------------------------------
// utsg_pkg
// Shared types, constants and the boundary character table for the UTF-8
// text pre-segmenter.
// ----------------------------------------------------------------------------
package utsg_pkg;

   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 32;
   localparam int HELD_W  = 24;
   localparam int COUNT_W = 2;
   localparam int LEN_W   = 3;

   localparam logic [BYTE_W-1:0] LEAD_TWO_MIN   = 8'd128;
   localparam logic [BYTE_W-1:0] LEAD_THREE_MIN = 8'd224;
   localparam logic [BYTE_W-1:0] LEAD_FOUR_MIN  = 8'd240;

   localparam int BOUNDARY_COUNT = 27;

   typedef enum logic [1:0] {
      KIND_ORDINARY = 2'd0,
      KIND_PUNCT    = 2'd1,
      KIND_SPACE    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [HELD_W-1:0] code;
      logic [LEN_W-1:0]  len;
      kind_type          kind;
   } boundary_entry_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
   } byte_in_type;

   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      kind_type          kind;
      logic              fresh;
      logic              last;
   } char_result_type;

   localparam boundary_entry_type BOUNDARY_TABLE [BOUNDARY_COUNT] = '{
      '{24'h8280E3, 3'd3, KIND_PUNCT},   // U+3002
      '{24'h8CBCEF, 3'd3, KIND_PUNCT},   // U+FF0C
      '{24'h8180E3, 3'd3, KIND_PUNCT},   // U+3001
      '{24'h9BBCEF, 3'd3, KIND_PUNCT},   // U+FF1B
      '{24'h9ABCEF, 3'd3, KIND_PUNCT},   // U+FF1A
      '{24'h9FBCEF, 3'd3, KIND_PUNCT},   // U+FF1F
      '{24'h81BCEF, 3'd3, KIND_PUNCT},   // U+FF01
      '{24'hA680E2, 3'd3, KIND_PUNCT},   // U+2026
      '{24'h9480E2, 3'd3, KIND_PUNCT},   // U+2014
      '{24'h9C80E2, 3'd3, KIND_PUNCT},   // U+201C
      '{24'h9D80E2, 3'd3, KIND_PUNCT},   // U+201D
      '{24'h9880E2, 3'd3, KIND_PUNCT},   // U+2018
      '{24'h9980E2, 3'd3, KIND_PUNCT},   // U+2019
      '{24'h88BCEF, 3'd3, KIND_PUNCT},   // U+FF08
      '{24'h89BCEF, 3'd3, KIND_PUNCT},   // U+FF09
      '{24'h8A80E3, 3'd3, KIND_PUNCT},   // U+300A
      '{24'h8B80E3, 3'd3, KIND_PUNCT},   // U+300B
      '{24'h00000A, 3'd1, KIND_SPACE},
      '{24'h00000D, 3'd1, KIND_SPACE},
      '{24'h000020, 3'd1, KIND_SPACE},
      '{24'h8080E3, 3'd3, KIND_SPACE},   // U+3000
      '{24'h00002E, 3'd1, KIND_PUNCT},
      '{24'h00002C, 3'd1, KIND_PUNCT},
      '{24'h00003B, 3'd1, KIND_PUNCT},
      '{24'h00003A, 3'd1, KIND_PUNCT},
      '{24'h00003F, 3'd1, KIND_PUNCT},
      '{24'h000021, 3'd1, KIND_PUNCT}
   };

   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] n;
      if (b < LEAD_TWO_MIN) begin
         n = 3'd1;
      end else if (b < LEAD_THREE_MIN) begin
         n = 3'd2;
      end else if (b < LEAD_FOUR_MIN) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

endpackage

@@ src/utsg_boundary_match.sv @@
// ----------------------------------------------------------------------------
// utsg_boundary_match
// Parallel compare of one completed character against the boundary table.
// ----------------------------------------------------------------------------
module utsg_boundary_match
   import utsg_pkg::*;
(
   input  logic [CODE_W-1:0] code,
   input  logic [LEN_W-1:0]  len,
   output kind_type          kind
);

   logic [BOUNDARY_COUNT-1:0] hit;

   always_comb begin
      for (int i = 0; i < BOUNDARY_COUNT; i++) begin
         hit[i] = (code[CODE_W-1:HELD_W] == '0) &&
                  (code[HELD_W-1:0] == BOUNDARY_TABLE[i].code) &&
                  (len == BOUNDARY_TABLE[i].len);
      end
   end

   // entries are distinct, so at most one hit
   always_comb begin
      kind = KIND_ORDINARY;
      for (int i = 0; i < BOUNDARY_COUNT; i++) begin
         if (hit[i]) begin
            kind = BOUNDARY_TABLE[i].kind;
         end
      end
   end

endmodule

@@ src/utsg_char_assembler.sv @@
// ----------------------------------------------------------------------------
// utsg_char_assembler
// Gathers bytes into characters and tracks the open segment.
// ----------------------------------------------------------------------------
module utsg_char_assembler
   import utsg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  byte_in_type     byte_in,
   input  logic            step,
   output char_result_type result
);

   logic [HELD_W-1:0]  held_bytes_ff, held_bytes_in;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic [LEN_W-1:0]   expected_len_ff, expected_len_in;
   logic               segment_open_ff, segment_open_in;

   logic [LEN_W-1:0]   exp_len;
   logic [CODE_W-1:0]  code;
   logic [LEN_W-1:0]   len;
   logic               hold;
   kind_type           kind;

   always_comb begin
      exp_len = (held_count_ff == '0) ? lead_length(byte_in.data) : expected_len_ff;
      code    = {{(CODE_W-HELD_W){1'b0}}, held_bytes_ff} |
                (CODE_W'(byte_in.data) << {held_count_ff, 3'b000});
      len     = {1'b0, held_count_ff} + 3'd1;
      hold    = (len < exp_len) && !byte_in.last;
   end

   utsg_boundary_match u_match (
      .code (code),
      .len  (len),
      .kind (kind)
   );

   always_comb begin
      result.emit  = byte_in.valid && !hold;
      result.code  = code;
      result.len   = len;
      result.kind  = kind;
      result.last  = byte_in.last;
      unique case (kind)
         KIND_ORDINARY: result.fresh = !segment_open_ff;
         KIND_PUNCT:    result.fresh = 1'b1;
         default:       result.fresh = 1'b0;
      endcase

      held_bytes_in   = held_bytes_ff;
      held_count_in   = held_count_ff;
      expected_len_in = expected_len_ff;
      segment_open_in = segment_open_ff;
      if (step && byte_in.valid) begin
         if (hold) begin
            held_bytes_in   = code[HELD_W-1:0];
            held_count_in   = len[COUNT_W-1:0];
            expected_len_in = exp_len;
         end else begin
            held_bytes_in   = '0;
            held_count_in   = '0;
            expected_len_in = 3'd1;
            segment_open_in = (kind == KIND_ORDINARY) && !byte_in.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff   <= '0;
         held_count_ff   <= '0;
         expected_len_ff <= 3'd1;
         segment_open_ff <= 1'b0;
      end else begin
         held_bytes_ff   <= held_bytes_in;
         held_count_ff   <= held_count_in;
         expected_len_ff <= expected_len_in;
         segment_open_ff <= segment_open_in;
      end
   end

endmodule

@@ src/utf8_text_pre_segmenter_core.sv @@
// ----------------------------------------------------------------------------
// utf8_text_pre_segmenter_core
// UTF-8 byte stream to character stream with segment boundary marks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per request; req_tlast marks the final byte
//   of a text. rsp_* carries one request per completed character with its
//   bytes and length in rsp_tdata, its kind and new-segment flag in
//   rsp_tuser, and rsp_tlast on the character closed by the final byte.
//   Bytes that only extend a character give no response.
//   A byte taken into the input register goes via the classifier into the
//   result register before its character shows on rsp_*. Throughput is one
//   byte per cycle while the receiver does not stall, set by the single
//   register stage in front of the classifier and the result register behind it.
//   Reset (synchronous, active high) empties both registers and returns the
//   character and segment state to the start of a text.
//   When the receiver stalls, the result register holds; one more byte is
//   taken into the input register, and bytes that complete no character
//   keep flowing until a character needs the result register.
// ----------------------------------------------------------------------------
module utf8_text_pre_segmenter_core
   import utsg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] char_code, [34:32] char_len, rest zero
   output logic [2:0]  rsp_tuser,   // [1:0] kind, [2] new_segment
   output logic        rsp_tlast    // text_end
);

   byte_in_type     in_ff, in_in;
   char_result_type res;
   logic            advance;

   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] out_code_ff;
   logic [LEN_W-1:0]  out_len_ff;
   kind_type          out_kind_ff;
   logic              out_fresh_ff;
   logic              out_last_ff;

   always_comb begin
      advance    = in_ff.valid && (!res.emit || !out_valid_ff || rsp_tready);
      req_tready = !in_ff.valid || advance;

      in_in = in_ff;
      if (req_tready) begin
         in_in.valid = req_tvalid;
         in_in.data  = req_tdata;
         in_in.last  = req_tlast;
      end

      if (advance && res.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   utsg_char_assembler u_assembler (
      .clock   (clock),
      .reset   (reset),
      .byte_in (in_ff),
      .step    (advance),
      .result  (res)
   );

   always_ff @(posedge clock) begin
      in_ff.data <= in_in.data;
      in_ff.last <= in_in.last;
      if (reset) begin
         in_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_ff.valid  <= in_in.valid;
         out_valid_ff <= out_valid_in;
      end
      if (advance && res.emit) begin
         out_code_ff  <= res.code;
         out_len_ff   <= res.len;
         out_kind_ff  <= res.kind;
         out_fresh_ff <= res.fresh;
         out_last_ff  <= res.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_len_ff, out_code_ff};
   assign rsp_tuser  = {out_fresh_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_len_ff >= 3'd1 && out_len_ff <= 3'd4))
      else $error("character length out of range");

   a_space_no_segment: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kind_ff == KIND_SPACE) |-> !out_fresh_ff)
      else $error("dropped separator flagged as new segment");

   a_punct_segment: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kind_ff == KIND_PUNCT) |-> out_fresh_ff)
      else $error("punctuation not flagged as new segment");

   a_boundary_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kind_ff != KIND_ORDINARY) |->
         (out_len_ff == 3'd1 || out_len_ff == 3'd3))
      else $error("boundary match with impossible length");
`endif

endmodule

@@ verif/utf8_text_pre_segmenter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_text_pre_segmenter_checker
// Watches both channels of the pre-segmenter, predicts each character from
// the accepted text bytes and compares every response field by field.
// ----------------------------------------------------------------------------
module utf8_text_pre_segmenter_checker
   import utsg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] char_code, [34:32] char_len, rest zero
   input  logic [2:0]  rsp_tuser,   // [1:0] kind, [2] new_segment
   input  logic        rsp_tlast,   // text_end
   output int          mismatch_count,
   output int          pending_chars,
   output int          chars_checked
);

   typedef struct packed {
      logic [31:0] code;
      logic [2:0]  len;
      kind_type    kind;
      logic        fresh;
      logic        text_end;
   } char_expect_type;

   char_expect_type expected_chars[$];

   // character assembly and segment state
   logic [23:0] gathered_bytes = '0;
   logic [1:0]  gathered_count = '0;
   logic [2:0]  char_length    = 3'd1;
   logic        segment_open   = 1'b0;

   int errors_seen  = 0;
   int checked_seen = 0;

   function automatic logic [2:0] lead_to_length(input logic [7:0] lead);
      logic [2:0] n;
      if (lead < 8'd128) begin
         n = 3'd1;
      end else if (lead < 8'd224) begin
         n = 3'd2;
      end else if (lead < 8'd240) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic kind_type boundary_kind(input logic [31:0] code, input logic [2:0] len);
      kind_type k;
      k = KIND_ORDINARY;
      if (len == 3'd1) begin
         case (code)
            32'h0A, 32'h0D, 32'h20: k = KIND_SPACE;
            32'h2E, 32'h2C, 32'h3B, 32'h3A, 32'h3F, 32'h21: k = KIND_PUNCT;
            default: k = KIND_ORDINARY;
         endcase
      end else if (len == 3'd3) begin
         case (code)
            32'h8080E3: k = KIND_SPACE;
            32'h8280E3, 32'h8CBCEF, 32'h8180E3, 32'h9BBCEF, 32'h9ABCEF, 32'h9FBCEF,
            32'h81BCEF, 32'hA680E2, 32'h9480E2, 32'h9C80E2, 32'h9D80E2, 32'h9880E2,
            32'h9980E2, 32'h88BCEF, 32'h89BCEF, 32'h8A80E3, 32'h8B80E3: k = KIND_PUNCT;
            default: k = KIND_ORDINARY;
         endcase
      end
      return k;
   endfunction

   task automatic segment_byte(input logic [7:0] b, input logic final_byte);
      logic [31:0]     code;
      logic [2:0]      len;
      char_expect_type e;
      if (gathered_count == 2'd0) char_length = lead_to_length(b);
      code = {8'h00, gathered_bytes} | (32'(b) << (8 * gathered_count));
      len  = 3'(gathered_count) + 3'd1;
      if (len < char_length && !final_byte) begin
         gathered_bytes = code[23:0];
         gathered_count = len[1:0];
      end else begin
         e.code = code;
         e.len  = len;
         e.kind = boundary_kind(code, len);
         case (e.kind)
            KIND_ORDINARY: begin
               e.fresh = !segment_open;
               segment_open = 1'b1;
            end
            KIND_PUNCT: begin
               e.fresh = 1'b1;
               segment_open = 1'b0;
            end
            default: begin
               e.fresh = 1'b0;
               segment_open = 1'b0;
            end
         endcase
         e.text_end = final_byte;
         expected_chars = {expected_chars, e};
         gathered_bytes = '0;
         gathered_count = '0;
         char_length    = 3'd1;
         if (final_byte) segment_open = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR: character %0d, %s: got 0x%0h, expected 0x%0h",
               checked_seen, field, got, want);
      errors_seen++;
   endtask

   task automatic check_char();
      char_expect_type e;
      if (expected_chars.size() == 0) begin
         report_mismatch("response with none pending, char_code", rsp_tdata[31:0], '0);
      end else begin
         e = expected_chars.pop_front();
         if (rsp_tdata[31:0] !== e.code) report_mismatch("char_code", rsp_tdata[31:0], e.code);
         if (rsp_tdata[34:32] !== e.len) report_mismatch("char_len", rsp_tdata[34:32], e.len);
         if (rsp_tdata[39:35] !== 5'd0) report_mismatch("tdata padding", rsp_tdata[39:35], '0);
         if (rsp_tuser[1:0] !== e.kind) report_mismatch("kind", rsp_tuser[1:0], e.kind);
         if (rsp_tuser[2] !== e.fresh) report_mismatch("new_segment", rsp_tuser[2], e.fresh);
         if (rsp_tlast !== e.text_end) report_mismatch("text_end", rsp_tlast, e.text_end);
         checked_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gathered_bytes = '0;
         gathered_count = '0;
         char_length    = 3'd1;
         segment_open   = 1'b0;
         expected_chars.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_char();
         if (req_tvalid && req_tready) segment_byte(req_tdata, req_tlast);
      end
      mismatch_count <= errors_seen;
      pending_chars  <= expected_chars.size();
      chars_checked  <= checked_seen;
   end

endmodule

@@ verif/utf8_text_pre_segmenter_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_text_pre_segmenter_core_test
// Feeds the pre-segmenter directed and random UTF-8 texts, including
// boundary characters, broken sequences and texts cut mid-character, with
// random gaps and stalls on both channels; the checker scores the results.
// ----------------------------------------------------------------------------
module utf8_text_pre_segmenter_core_test;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatch_count;
   int pending_chars;
   int chars_checked;

   int  bytes_sent     = 0;
   int  texts_sent     = 0;
   int  texts_cut      = 0;
   int  drain_pauses   = 0;
   bit  send_steady    = 1'b0;
   bit  take_steady    = 1'b0;
   int  last_char_len  = 0;

   logic [7:0] text_bytes[$];

   logic [7:0]  ascii_marks [9] = '{8'h0A, 8'h0D, 8'h20, 8'h2E, 8'h2C, 8'h3B,
                                     8'h3A, 8'h3F, 8'h21};
   logic [23:0] wide_marks [18] = '{24'h8280E3, 24'h8CBCEF, 24'h8180E3, 24'h9BBCEF,
                                     24'h9ABCEF, 24'h9FBCEF, 24'h81BCEF, 24'hA680E2,
                                     24'h9480E2, 24'h9C80E2, 24'h9D80E2, 24'h9880E2,
                                     24'h9980E2, 24'h88BCEF, 24'h89BCEF, 24'h8A80E3,
                                     24'h8B80E3, 24'h8080E3};

   utf8_text_pre_segmenter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_text_pre_segmenter_checker char_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_chars  (pending_chars),
      .chars_checked  (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic final_byte);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= final_byte;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
      texts_sent++;
   endtask

   // hold the sender until every pending character has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
   endtask

   task automatic append_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
   endtask

   task automatic add_char();
      int          pick;
      int          n;
      logic [23:0] w;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         append_byte(8'($urandom_range(0, 127)));
         last_char_len = 1;
      end else if (pick < 45) begin
         append_byte(ascii_marks[$urandom_range(0, 8)]);
         last_char_len = 1;
      end else if (pick < 60 || pick >= 90) begin
         // boundary char, or a near miss with a random final byte
         w = wide_marks[$urandom_range(0, 17)];
         if (pick >= 90) w[23:16] = 8'($urandom_range(128, 191));
         append_byte(w[7:0]);
         append_byte(w[15:8]);
         append_byte(w[23:16]);
         last_char_len = 3;
      end else if (pick < 80) begin
         n = $urandom_range(2, 4);
         case (n)
            2: append_byte(8'($urandom_range(8'hC2, 8'hDF)));
            3: append_byte(8'($urandom_range(8'hE0, 8'hEF)));
            default: append_byte(8'($urandom_range(8'hF0, 8'hF7)));
         endcase
         repeat (n - 1) append_byte(8'($urandom_range(8'h80, 8'hBF)));
         last_char_len = n;
      end else begin
         // raw noise: stray continuations and invalid leads
         append_byte(8'($urandom_range(0, 255)));
         last_char_len = 1;
      end
   endtask

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = take_steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ordinary run, punctuation, whitespace, NUL, wide punct and space,
      // stray continuation, 4-byte char, text cut inside a 3-byte char
      text_bytes = '{8'h61, 8'h62, 8'h2C, 8'h63, 8'h20, 8'h0A, 8'h0D, 8'h2E, 8'h3B,
                     8'h00, 8'hE3, 8'h80, 8'h82, 8'hE3, 8'h80, 8'h80, 8'h80, 8'h7F,
                     8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE3, 8'h80};
      send_text();
      texts_cut++;
      // lone 4-byte lead ending the text
      text_bytes = '{8'hFF};
      send_text();
      texts_cut++;

      while (bytes_sent < 1500) begin
         send_steady = ($urandom_range(0, 3) == 0);
         take_steady = ($urandom_range(0, 3) == 0);
         text_bytes.delete();
         n = $urandom_range(1, 30);
         repeat (n) add_char();
         if (last_char_len > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, last_char_len - 1)) void'(text_bytes.pop_back());
            texts_cut++;
         end
         send_text();
         if ($urandom_range(0, 7) == 0) begin
            drain();
            drain_pauses++;
         end
      end

      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d text bytes in %0d texts (%0d cut mid-character), %0d full drains.",
               bytes_sent, texts_sent, texts_cut, drain_pauses);
      $display("Checked %0d characters under random gaps and stalls.", chars_checked);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
